>>> rtl/core/rmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmt_pkg
// shared widths, opcodes and arithmetic helpers of the regret matching table
// ----------------------------------------------------------------------------
package rmt_pkg;

  localparam int SET_COUNT   = 4096;
  localparam int MAX_ACTIONS = 8;
  localparam int SET_W       = $clog2(SET_COUNT);
  localparam int SLOT_W      = $clog2(MAX_ACTIONS);
  localparam int ADDR_W      = SET_W + SLOT_W;
  localparam int CNT_W       = 4;
  localparam int N_LIMIT     = (MAX_ACTIONS < 8) ? MAX_ACTIONS : 8;
  localparam int ACC_W       = 48;
  localparam int VAL_W       = 32;
  localparam int SUM_W       = ACC_W + SLOT_W;
  localparam int PROB_W      = 17;
  localparam int DRAW_W      = 16;
  localparam int CUM_W       = PROB_W + SLOT_W;

  localparam logic [2:0] OP_ADD_REGRET = 3'd0;
  localparam logic [2:0] OP_ADD_STRAT  = 3'd1;
  localparam logic [2:0] OP_READ_RM    = 3'd2;
  localparam logic [2:0] OP_SAMPLE     = 3'd3;
  localparam logic [2:0] OP_READ_AVG   = 3'd4;

  // saturating accumulate of a Q16.16 delta into a Q32.16 accumulator
  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0] acc,
    input logic signed [VAL_W-1:0] delta
  );
    logic signed [ACC_W:0] s;
    s = {acc[ACC_W-1], acc} + (ACC_W+1)'(delta);
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat_add = s[ACC_W-1:0];
    end
  endfunction

  // floor(1.0 / n) in Q1.16 for the legal action counts
  function automatic logic [PROB_W-1:0] uniform_prob(input logic [CNT_W-1:0] n);
    case (n)
      4'd1:    uniform_prob = 17'd65536;
      4'd2:    uniform_prob = 17'd32768;
      4'd3:    uniform_prob = 17'd21845;
      4'd4:    uniform_prob = 17'd16384;
      4'd5:    uniform_prob = 17'd13107;
      4'd6:    uniform_prob = 17'd10922;
      4'd7:    uniform_prob = 17'd9362;
      default: uniform_prob = 17'd8192;
    endcase
  endfunction

endpackage

>>> rtl/core/rmt_acc_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmt_acc_mem
// single port accumulator memory, registered read
// ----------------------------------------------------------------------------
module rmt_acc_mem import rmt_pkg::*; (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [ADDR_W-1:0]       addr_i,
  input  logic signed [ACC_W-1:0] wdata_i,
  output logic signed [ACC_W-1:0] rdata_o
);

  logic signed [ACC_W-1:0] mem [SET_COUNT*MAX_ACTIONS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

>>> rtl/core/rmt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmt_div
// restoring divider, floor(num * 2^16 / den) for num <= den, one bit a cycle
// ----------------------------------------------------------------------------
module rmt_div import rmt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SUM_W-1:0]  num_i,
  input  logic [SUM_W-1:0]  den_i,
  output logic              done_o,
  output logic [PROB_W-1:0] quot_o
);

  logic [SUM_W:0]        rem_q, rem_d, trial;
  logic [SUM_W-1:0]      den_q;
  logic [PROB_W-1:0]     quot_q, quot_d;
  logic [4:0]            cnt_q, cnt_d;
  logic                  busy_q, busy_d, first_q, first_d, done_q, done_d;

  always_comb begin
    rem_d   = rem_q;
    quot_d  = quot_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    first_d = first_q;
    done_d  = 1'b0;
    trial   = first_q ? rem_q : {rem_q[SUM_W-1:0], 1'b0};
    if (start_i) begin
      rem_d   = {1'b0, num_i};
      quot_d  = '0;
      cnt_d   = 5'(PROB_W);
      busy_d  = 1'b1;
      first_d = 1'b1;
    end else if (busy_q) begin
      first_d = 1'b0;
      if (trial >= {1'b0, den_q}) begin
        rem_d  = trial - {1'b0, den_q};
        quot_d = {quot_q[PROB_W-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[PROB_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      first_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      first_q <= first_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> rtl/core/regret_matching_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// regret_matching_table
// per information set regret and strategy accumulators with regret matching,
// sampling and average strategy readout
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  in      | into      | in_valid_i / in_stall_o    | opcode, set, action, count, value, draw
//  out     | out of    | out_valid_o / out_stall_i  | action, probability, status, last
//
// updates step through read, saturating add and write back, then a result;
// queries first read and sum every slot, then per slot read it, divide in
// the shared bit-serial divider and decide; reads emit every slot, a sample
// only the chosen one; with a sum not above zero the divider is skipped
// after reset a clearing pass writes zero to all 32768 entries of both
// memories, one a cycle; in_stall_o stays high during the whole pass
// a request is taken only when idle; output stalls hold results in place
// ----------------------------------------------------------------------------
module regret_matching_table import rmt_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [2:0]              opcode_i,
  input  logic [11:0]             set_index_i,
  input  logic [2:0]              action_index_i,
  input  logic [CNT_W-1:0]        action_count_i,
  input  logic signed [VAL_W-1:0] update_value_i,
  input  logic [DRAW_W-1:0]       random_draw_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [2:0]              result_action_o,
  output logic [PROB_W-1:0]       probability_o,
  output logic                    status_o,
  output logic                    last_of_run_o
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_URD   = 4'd2;
  localparam logic [3:0] S_UWR   = 4'd3;
  localparam logic [3:0] S_SRD   = 4'd4;
  localparam logic [3:0] S_SACC  = 4'd5;
  localparam logic [3:0] S_PRD   = 4'd6;
  localparam logic [3:0] S_PCALC = 4'd7;
  localparam logic [3:0] S_PDIV  = 4'd8;
  localparam logic [3:0] S_PDEC  = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  logic [3:0]              state_q, state_d;
  logic [ADDR_W-1:0]       clr_q, clr_d;
  logic [2:0]              op_q, op_d;
  logic [SET_W-1:0]        set_q, set_d;
  logic [SLOT_W-1:0]       act_q, act_d, idx_q, idx_d;
  logic [CNT_W-1:0]        n_q, n_d, n_in;
  logic signed [VAL_W-1:0] val_q, val_d;
  logic [DRAW_W-1:0]       draw_q, draw_d;
  logic                    status_q, status_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [CUM_W-1:0]        cum_q, cum_d, cum_new;
  logic [PROB_W-1:0]       prob_q, prob_d;

  logic                    out_valid_q, out_valid_d;
  logic [2:0]              res_act_q, res_act_d;
  logic [PROB_W-1:0]       res_prob_q, res_prob_d;
  logic                    res_status_q, res_status_d, res_last_q, res_last_d;

  // memory side
  logic                    use_strat, mem_we;
  logic [ADDR_W-1:0]       mem_addr;
  logic signed [ACC_W-1:0] mem_wdata, rg_rdata, st_rdata, rdata;
  logic signed [SUM_W-1:0] rdata_x;
  logic [SUM_W-1:0]        div_num;
  logic                    div_start, div_done;
  logic [PROB_W-1:0]       div_quot;

  logic                    accept, idx_last, out_free, is_upd;

  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign use_strat = (op_q == OP_ADD_STRAT) || (op_q == OP_READ_AVG);
  assign is_upd    = (op_q == OP_ADD_REGRET) || (op_q == OP_ADD_STRAT);
  assign idx_last  = ({1'b0, idx_q} == (n_q - CNT_W'(1)));
  assign rdata     = use_strat ? st_rdata : rg_rdata;
  assign rdata_x   = SUM_W'(rdata);
  assign cum_new   = cum_q + CUM_W'(prob_q);

  // clamp action count into 1 .. limit
  always_comb begin
    n_in = action_count_i;
    if (action_count_i == '0) n_in = CNT_W'(1);
    if (action_count_i > CNT_W'(N_LIMIT)) n_in = CNT_W'(N_LIMIT);
  end

  // memory address and write data
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = sat_add(rdata, val_q);
    mem_addr  = {set_q, idx_q};
    if (state_q == S_CLR) begin
      mem_we    = 1'b1;
      mem_wdata = '0;
      mem_addr  = clr_q;
    end else if (state_q == S_URD || state_q == S_UWR) begin
      mem_addr = {set_q, act_q};
      mem_we   = (state_q == S_UWR);
    end
  end

  // numerator clamped to [0, sum]; regret numerators never exceed the sum
  always_comb begin
    if (rdata_x < 0) begin
      div_num = '0;
    end else if (rdata_x > sum_q) begin
      div_num = sum_q;
    end else begin
      div_num = rdata_x;
    end
  end

  assign div_start = (state_q == S_PCALC) && (sum_q > 0);

  rmt_acc_mem u_regret_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we && (state_q == S_CLR || !use_strat)),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (rg_rdata)
  );

  rmt_acc_mem u_strat_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we && (state_q == S_CLR || use_strat)),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (st_rdata)
  );

  rmt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (sum_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // sequencer
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    op_d         = op_q;
    set_d        = set_q;
    act_d        = act_q;
    idx_d        = idx_q;
    n_d          = n_q;
    val_d        = val_q;
    draw_d       = draw_q;
    status_d     = status_q;
    sum_d        = sum_q;
    cum_d        = cum_q;
    prob_d       = prob_q;
    out_valid_d  = out_valid_q && out_stall_i;
    res_act_d    = res_act_q;
    res_prob_d   = res_prob_q;
    res_status_d = res_status_q;
    res_last_d   = res_last_q;

    unique case (state_q)
      S_CLR: begin
        clr_d = clr_q + ADDR_W'(1);
        if (clr_q == {ADDR_W{1'b1}}) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          op_d     = opcode_i;
          set_d    = set_index_i[SET_W-1:0];
          act_d    = action_index_i[SLOT_W-1:0];
          n_d      = n_in;
          val_d    = update_value_i;
          draw_d   = random_draw_i;
          idx_d    = '0;
          sum_d    = '0;
          cum_d    = '0;
          status_d = 1'b0;
          if (opcode_i == OP_ADD_REGRET || opcode_i == OP_ADD_STRAT) begin
            // write outside the legal actions: ignored, flagged
            if ({1'b0, action_index_i} >= n_in) begin
              status_d = 1'b1;
              state_d  = S_EMIT;
            end else begin
              state_d = S_URD;
            end
          end else if (opcode_i == OP_READ_RM || opcode_i == OP_SAMPLE ||
                       opcode_i == OP_READ_AVG) begin
            state_d = S_SRD;
          end
        end
      end
      S_URD:  state_d = S_UWR;
      S_UWR:  state_d = S_EMIT;
      S_SRD:  state_d = S_SACC;
      S_SACC: begin
        // average sums signed slots, regret matching only positive ones
        if (use_strat || rdata > 0) sum_d = sum_q + rdata_x;
        if (idx_last) begin
          idx_d   = '0;
          state_d = S_PRD;
        end else begin
          idx_d   = idx_q + SLOT_W'(1);
          state_d = S_SRD;
        end
      end
      S_PRD: state_d = S_PCALC;
      S_PCALC: begin
        if (sum_q > 0) begin
          state_d = S_PDIV;
        end else begin
          prob_d  = uniform_prob(n_q);
          state_d = S_PDEC;
        end
      end
      S_PDIV: begin
        if (div_done) begin
          prob_d  = div_quot;
          state_d = S_PDEC;
        end
      end
      S_PDEC: begin
        if (op_q != OP_SAMPLE) begin
          state_d = S_EMIT;
        end else if ({{(CUM_W-DRAW_W){1'b0}}, draw_q} < cum_new || idx_last) begin
          state_d = S_EMIT;
        end else begin
          cum_d   = cum_new;
          idx_d   = idx_q + SLOT_W'(1);
          state_d = S_PRD;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          res_act_d    = is_upd ? 3'(act_q) : 3'(idx_q);
          res_prob_d   = is_upd ? '0 : prob_q;
          res_status_d = status_q;
          res_last_d   = is_upd || (op_q == OP_SAMPLE) || idx_last;
          if (is_upd || (op_q == OP_SAMPLE) || idx_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + SLOT_W'(1);
            state_d = S_PRD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    set_q        <= set_d;
    act_q        <= act_d;
    idx_q        <= idx_d;
    n_q          <= n_d;
    val_q        <= val_d;
    draw_q       <= draw_d;
    status_q     <= status_d;
    sum_q        <= sum_d;
    cum_q        <= cum_d;
    prob_q       <= prob_d;
    res_act_q    <= res_act_d;
    res_prob_q   <= res_prob_d;
    res_status_q <= res_status_d;
    res_last_q   <= res_last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign result_action_o = res_act_q;
  assign probability_o   = res_prob_q;
  assign status_o        = res_status_q;
  assign last_of_run_o   = res_last_q;

endmodule

>>> rtl/core/rmt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmt_checker
// port level checks of the regret matching table
// ----------------------------------------------------------------------------
module rmt_checker import rmt_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [2:0]              result_action_o,
  input logic [PROB_W-1:0]       probability_o,
  input logic                    status_o,
  input logic                    last_of_run_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(probability_o) &&
    $stable(result_action_o) && $stable(status_o) && $stable(last_of_run_o))
    else $error("stalled result changed");

  // rejected write is a lone acknowledgement
  a_status_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> probability_o == '0 && last_of_run_o)
    else $error("status result malformed");

  a_prob_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> probability_o <= PROB_W'(65536))
    else $error("probability above one");

  // clearing pass blocks requests right after reset
  a_reset_stall: assert property (@(posedge clk_i)
    !rst_ni |=> in_stall_o && !out_valid_o)
    else $error("request possible during clearing");

endmodule

bind regret_matching_table rmt_checker u_rmt_checker (.*);

>>> tb/sv/regret_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// regret_table_checker
// watches both channels, keeps its own copy of the regret and strategy
// accumulators, predicts every result and compares it field by field
// ----------------------------------------------------------------------------
module regret_table_checker import rmt_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [2:0]              opcode_i,
  input  logic [11:0]             set_index_i,
  input  logic [2:0]              action_index_i,
  input  logic [CNT_W-1:0]        action_count_i,
  input  logic signed [VAL_W-1:0] update_value_i,
  input  logic [DRAW_W-1:0]       random_draw_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [2:0]              result_action_i,
  input  logic [PROB_W-1:0]       probability_i,
  input  logic                    status_i,
  input  logic                    last_of_run_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  typedef struct packed {
    logic [2:0]        action;
    logic [PROB_W-1:0] prob;
    logic              status;
    logic              last;
  } table_result_t;

  localparam logic signed [ACC_W-1:0] ACC_HI = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_LO = {1'b1, {(ACC_W-1){1'b0}}};

  // sparse copies of both stores, absent entries read as zero
  logic signed [ACC_W-1:0] regret_acc [int];
  logic signed [ACC_W-1:0] strat_acc [int];
  table_result_t           result_q [$];
  int                      fails;

  function automatic logic signed [ACC_W-1:0] regret_at(int addr);
    return regret_acc.exists(addr) ? regret_acc[addr] : '0;
  endfunction

  function automatic logic signed [ACC_W-1:0] strat_at(int addr);
    return strat_acc.exists(addr) ? strat_acc[addr] : '0;
  endfunction

  // append one expected result at the tail
  function automatic void queue_result(table_result_t r);
    result_q.insert(result_q.size(), r);
  endfunction

  function automatic logic signed [ACC_W-1:0] clamp_add(logic signed [ACC_W-1:0] acc,
                                                         logic signed [VAL_W-1:0] d);
    logic signed [ACC_W+1:0] s;
    s = acc + d;
    if (s > ACC_HI) return ACC_HI;
    if (s < ACC_LO) return ACC_LO;
    return s[ACC_W-1:0];
  endfunction

  // regret matching: positive regrets normalized, uniform when none positive
  function automatic void matched_probs(int base, int n, output logic [PROB_W-1:0] p [8]);
    logic [69:0] total, pos;
    logic signed [ACC_W-1:0] r;
    total = '0;
    for (int i = 0; i < n; i++) begin
      r = regret_at(base + i);
      if (r > 0) total += r;
    end
    for (int i = 0; i < 8; i++) begin
      r = regret_at(base + i);
      pos = (r > 0) ? r : '0;
      if (total == 0) p[i] = 17'(65536 / n);
      else p[i] = 17'((pos << 16) / total);
    end
  endfunction

  function automatic void average_probs(int base, int n, output logic [PROB_W-1:0] p [8]);
    logic signed [69:0] total, s;
    total = '0;
    for (int i = 0; i < n; i++) total += strat_at(base + i);
    for (int i = 0; i < 8; i++) begin
      s = strat_at(base + i);
      if (s < 0) s = 0;
      if (s > total) s = total;
      if (total <= 0) p[i] = 17'(65536 / n);
      else p[i] = 17'((s << 16) / total);
    end
  endfunction

  function automatic void predict_request(logic [2:0] op, logic [11:0] set,
                                          logic [2:0] act, logic [CNT_W-1:0] cnt,
                                          logic signed [VAL_W-1:0] val,
                                          logic [DRAW_W-1:0] draw);
    int n, base, pick;
    logic [PROB_W-1:0] p [8];
    logic [19:0] cum;
    table_result_t r;
    n = (cnt < 1) ? 1 : (cnt > N_LIMIT) ? N_LIMIT : int'(cnt);
    base = int'(set) * MAX_ACTIONS;
    case (op) inside
      OP_ADD_REGRET, OP_ADD_STRAT: begin
        r = '{action: act, prob: '0, status: 1'b1, last: 1'b1};
        if (act < n) begin
          r.status = 1'b0;
          if (op == OP_ADD_REGRET) regret_acc[base + act] = clamp_add(regret_at(base + act), val);
          else strat_acc[base + act] = clamp_add(strat_at(base + act), val);
        end
        queue_result(r);
      end
      OP_READ_RM, OP_READ_AVG: begin
        if (op == OP_READ_RM) matched_probs(base, n, p);
        else average_probs(base, n, p);
        for (int i = 0; i < n; i++)
          queue_result('{action: 3'(i), prob: p[i], status: 1'b0, last: (i == n - 1)});
      end
      OP_SAMPLE: begin
        matched_probs(base, n, p);
        cum = '0;
        pick = n - 1;
        for (int i = 0; i < n; i++) begin
          cum += p[i];
          if (draw < cum) begin
            pick = i;
            break;
          end
        end
        queue_result('{action: 3'(pick), prob: p[pick], status: 1'b0, last: 1'b1});
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    table_result_t exp_r;
    if (!rst_ni) begin
      regret_acc.delete();
      strat_acc.delete();
      result_q.delete();
      fails = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          $error("result with nothing expected: action %0d prob %0d", result_action_i,
                 probability_i);
          fails++;
        end else begin
          exp_r = result_q.pop_front();
          if (result_action_i !== exp_r.action) begin
            $error("result_action expected %0d got %0d", exp_r.action, result_action_i);
            fails++;
          end
          if (probability_i !== exp_r.prob) begin
            $error("probability expected %0d got %0d", exp_r.prob, probability_i);
            fails++;
          end
          if (status_i !== exp_r.status) begin
            $error("status expected %0d got %0d", exp_r.status, status_i);
            fails++;
          end
          if (last_of_run_i !== exp_r.last) begin
            $error("last_of_run expected %0d got %0d", exp_r.last, last_of_run_i);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        predict_request(opcode_i, set_index_i, action_index_i, action_count_i,
                        update_value_i, random_draw_i);
    end
  end

  assign fail_count_o = fails;
  assign pending_o    = result_q.size();

endmodule

>>> tb/sv/tb_regret_matching_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_regret_matching_table
// drives directed and random requests into the regret matching table with
// random gaps and output stalls; the checker predicts and compares results
// ----------------------------------------------------------------------------
module tb_regret_matching_table;
  import rmt_pkg::*;

  localparam int IDLE_LIMIT = 150000;  // covers the clearing pass after reset
  localparam int RANDOM_REQS = 415;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [2:0]              opcode_i;
  logic [11:0]             set_index_i;
  logic [2:0]              action_index_i;
  logic [CNT_W-1:0]        action_count_i;
  logic signed [VAL_W-1:0] update_value_i;
  logic [DRAW_W-1:0]       random_draw_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [2:0]              result_action_o;
  logic [PROB_W-1:0]       probability_o;
  logic                    status_o;
  logic                    last_of_run_o;
  int                      fail_count;
  int                      pending;
  int                      idle_cycles = 0;
  bit                      stall_quiet;  // stretch with no output stalls and no request gaps

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  regret_matching_table dut (.*);

  regret_table_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .opcode_i, .set_index_i,
    .action_index_i, .action_count_i, .update_value_i, .random_draw_i,
    .out_valid_i(out_valid_o), .out_stall_i, .result_action_i(result_action_o),
    .probability_i(probability_o), .status_i(status_o), .last_of_run_i(last_of_run_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(15, 4);
    return $urandom_range(80, 30);
  endfunction

  // output stall: each stall decision holds for a random run of cycles
  initial begin
    int hold;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      hold = gap_len();
      if (!stall_quiet && hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  // watchdog: cycles in which neither channel moves a request or a result
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // present one request and hold it until taken; valid stays high afterwards
  task automatic send(logic [2:0] op, logic [11:0] set, logic [2:0] act,
                      logic [CNT_W-1:0] cnt, logic signed [VAL_W-1:0] val,
                      logic [DRAW_W-1:0] draw);
    opcode_i       <= op;
    set_index_i    <= set;
    action_index_i <= act;
    action_count_i <= cnt;
    update_value_i <= val;
    random_draw_i  <= draw;
    in_valid_i     <= 1'b1;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic pause(int cycles);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // random value: mostly moderate deltas, sometimes any 32-bit pattern
  function automatic logic signed [VAL_W-1:0] rand_value();
    if ($urandom_range(9) < 2) return $urandom;
    return $signed($urandom_range(2 * 65536 * 8, 0)) - 65536 * 8;
  endfunction

  initial begin
    logic [11:0]      hot_set [6];
    logic [CNT_W-1:0] hot_cnt [6];
    logic [2:0]       op;
    logic [11:0]      set;
    logic [CNT_W-1:0] cnt;
    logic [2:0]       act;
    int               k, r;

    rst_ni         = 1'b0;
    in_valid_i    <= 1'b0;
    opcode_i      <= OP_ADD_REGRET;
    set_index_i   <= '0;
    action_index_i <= '0;
    action_count_i <= 4'd1;
    update_value_i <= '0;
    random_draw_i <= '0;
    stall_quiet    = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: all-zero regrets give uniform, then extremes of each field
    send(OP_READ_RM, 12'd0, 3'd0, 4'd8, 0, 16'd0);
    send(OP_READ_AVG, 12'd4095, 3'd0, 4'd3, 0, 16'd0);
    send(OP_ADD_REGRET, 12'd0, 3'd0, 4'd8, 32'sh7FFF_FFFF, 16'd0);
    send(OP_ADD_REGRET, 12'd0, 3'd7, 4'd8, 32'sh7FFF_FFFF, 16'd0);
    send(OP_ADD_REGRET, 12'd0, 3'd3, 4'd8, 32'sh8000_0000, 16'd0);
    send(OP_ADD_REGRET, 12'd0, 3'd5, 4'd8, 32'sd65536, 16'd0);
    send(OP_READ_RM, 12'd0, 3'd0, 4'd8, 0, 16'd0);
    send(OP_SAMPLE, 12'd0, 3'd0, 4'd8, 0, 16'd0);
    send(OP_SAMPLE, 12'd0, 3'd0, 4'd8, 0, 16'hFFFF);
    send(OP_SAMPLE, 12'd4095, 3'd0, 4'd5, 0, 16'd40000);
    // action index not below count: write ignored, status set
    send(OP_ADD_REGRET, 12'd4095, 3'd7, 4'd2, 32'sd1000, 16'd0);
    send(OP_ADD_STRAT, 12'd4095, 3'd4, 4'd0, 32'sd1000, 16'd0);
    // count zero treated as one, above eight treated as eight
    send(OP_READ_RM, 12'd5, 3'd0, 4'd0, 0, 16'd0);
    send(OP_READ_AVG, 12'd5, 3'd0, 4'd15, 0, 16'd0);
    // average: negative total gives uniform, a negative slot gets clamped to zero
    send(OP_ADD_STRAT, 12'd9, 3'd0, 4'd3, -32'sd5000, 16'd0);
    send(OP_READ_AVG, 12'd9, 3'd0, 4'd3, 0, 16'd0);
    send(OP_ADD_STRAT, 12'd9, 3'd1, 4'd3, 32'sd7000, 16'd0);
    send(OP_ADD_STRAT, 12'd9, 3'd2, 4'd3, 32'sd40000, 16'd0);
    send(OP_READ_AVG, 12'd9, 3'd0, 4'd3, 0, 16'd0);
    // unknown opcodes change nothing and return nothing
    send(3'd5, 12'd9, 3'd1, 4'd3, 32'sd99999, 16'd0);
    send(3'd6, 12'hAAA, 3'd2, 4'd3, 32'sd1, 16'd1);
    send(3'd7, 12'h555, 3'd5, 4'd9, -32'sd1, 16'hAAAA);
    send(OP_READ_AVG, 12'd9, 3'd0, 4'd3, 0, 16'd0);
    drain();

    // random: a few hot sets with a fixed count get most of the traffic
    foreach (hot_set[i]) begin
      hot_set[i] = (i == 0) ? 12'd0 : (i == 1) ? 12'd4095 : 12'($urandom);
      hot_cnt[i] = 4'($urandom_range(8, 1));
    end
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 100 == 0) stall_quiet = ($urandom_range(2) == 0);
      if (n == RANDOM_REQS / 2) drain();  // let every result come home first
      k   = $urandom_range(5);
      set = hot_set[k];
      cnt = hot_cnt[k];
      act = 3'($urandom_range(int'(cnt) - 1));
      r   = $urandom_range(99);
      if (r < 30) op = OP_ADD_REGRET;
      else if (r < 50) op = OP_ADD_STRAT;
      else if (r < 65) op = OP_READ_RM;
      else if (r < 83) op = OP_SAMPLE;
      else if (r < 95) op = OP_READ_AVG;
      else op = 3'($urandom_range(7, 5));
      // noise: any set, any count, any slot
      if ($urandom_range(9) == 0) begin
        set = 12'($urandom);
        cnt = 4'($urandom);
        act = 3'($urandom);
      end
      send(op, set, act, cnt, rand_value(), 16'($urandom));
      if (op > OP_READ_AVG) n--;
      if (!stall_quiet) pause(gap_len());
    end
    drain();

    repeat (300) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
